FILE: hw/rtl/particle_pool_engine_assert.svh
// Assertion macros shared by the particle pool engine RTL
`ifndef PARTICLE_POOL_ENGINE_ASSERT_SVH
`define PARTICLE_POOL_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define PPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("particle_pool_engine: assertion failed");

// Next-cycle implication, disabled while reset is low
`define PPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("particle_pool_engine: assertion failed");

`endif

FILE: hw/rtl/ppe_pkg.sv
// Package of types, constants and helpers for the particle pool engine
package ppe_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_STEP = CFG_IDX_W'(1);
    localparam logic [15:0] TIME_STEP_RST = 16'd1049;
    localparam logic [23:0] SPIN_STEP_RST = 24'd2684;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_Q_W = 16;

    typedef enum logic [1:0] {
        OP_EMIT = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TK_RD,
        S_TK_CHK,
        S_TK_Y,
        S_TK_WR,
        S_RD_RD,
        S_RD_CHK,
        S_RD_DIV,
        S_BL_MUL,
        S_BL_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               live;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        rot;
        logic [31:0]        col_b;
        logic [31:0]        col_e;
        logic [30:0]        life_time;
        logic signed [31:0] life_left;
        logic [15:0]        size_b;
        logic [15:0]        size_e;
    } t_slot_rec;

    typedef struct packed {
        logic                   start;
        logic [30:0]            num;
        logic [30:0]            den;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [DIV_Q_W-1:0]     quot;
    } t_div_rsp;

    localparam logic signed [34:0] SAT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SAT_MIN = 35'sh7_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] s);
        logic signed [31:0] r;
        if (s > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (s < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/ppe_slot_ram.sv
// Slot record memory: one write port and one registered read port
module ppe_slot_ram
    import ppe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_slot_rec         i_wdata,
    input  logic              i_re,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_slot_rec         o_rdata
);

    t_slot_rec r_mem [POOL_SIZE];
    t_slot_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ppe_mul.sv
// Shared signed multiplier with a registered product
module ppe_mul
    import ppe_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: hw/rtl/ppe_div.sv
// Restoring divider for the life fraction, one quotient bit per cycle
module ppe_div
    import ppe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [31:0]        r_rem;
    logic [30:0]        r_den;
    logic [DIV_Q_W-1:0] r_q;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [31:0]        n_trial;
    logic               n_fit;

    always_comb begin
        n_trial = {r_rem[30:0], 1'b0};
        n_fit   = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_fit ? (n_trial - {1'b0, r_den}) : n_trial;
            r_q   <= {r_q[DIV_Q_W-2:0], n_fit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: hw/rtl/particle_pool_engine.sv
// Top level of the particle pool engine: sequencer, registers and result stage
//
// Usage: one input channel (i_valid / o_stall) carries an op and its fields.
// Emit writes the slot at the ring pointer, marks it live and steps the
// pointer down, wrapping to the top slot. Tick walks all POOL_SIZE slots.
// Read returns one slot with size and colour blended by remaining life.
// Results appear only for read, on o_valid / i_stall; emit and tick give none.
// The config channel (i_cfg_valid / o_cfg_ready) writes time_step (index 0)
// or spin_step (index 1); other indexes are ignored. Ready is high only when idle.
// Tick reads each slot in turn and, for a live slot, steps x then y through
// the one shared multiplier before writing the slot back. Read fetches the
// slot, runs the bit-serial divider only when the life fraction needs it,
// then blends size and each colour byte through the same multiplier.
// One item is in flight at a time: o_stall is high until the block is idle.
// Reset: a clearing pass over all POOL_SIZE slots marks every slot dead; o_stall
// stays high meanwhile. A stalled result holds on the ports until taken.
`include "particle_pool_engine_assert.svh"
module particle_pool_engine
    import ppe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [9:0]  i_slot,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [31:0] i_color_begin,
    input  logic [31:0] i_color_end,
    input  logic [30:0] i_life_time,
    input  logic [15:0] i_size_begin,
    input  logic [15:0] i_size_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_active,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_rotation,
    output logic [15:0] o_out_size,
    output logic [31:0] o_out_color
);

    localparam logic [2:0] LANE_SIZE = 3'd0;
    localparam logic [2:0] LANE_C0   = 3'd1;
    localparam logic [2:0] LANE_C1   = 3'd2;
    localparam logic [2:0] LANE_C2   = 3'd3;
    localparam logic [2:0] LANE_C3   = 3'd4;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_next_slot;
    logic              r_oor;
    logic [15:0]       r_time_step;
    logic [23:0]       r_spin_step;
    t_slot_rec         r_rec;
    logic [16:0]       r_f;
    logic [2:0]        r_lane;

    logic              r_out_active;
    logic signed [31:0] r_out_x, r_out_y, r_out_rot;
    logic [15:0]       r_out_size;
    logic [31:0]       r_out_color;

    logic              in_acc;
    logic              last_idx;
    t_slot_rec         ram_rdata;
    t_slot_rec         ram_wdata;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic              rd_dead;
    logic              rd_zero_f;
    logic              rd_full_f;
    logic signed [34:0] step;
    logic signed [31:0] pos_new;
    logic [15:0]       bl_b, bl_e;
    logic signed [35:0] bl_acc;

    assign in_acc   = i_valid && !o_stall;
    assign last_idx = r_idx == LAST_SLOT;

    // A dead slot is one that is live with no life left.
    assign rd_dead   = ram_rdata.live && (ram_rdata.life_left <= 32'sd0);
    assign rd_zero_f = (ram_rdata.life_time == 31'd0) || (ram_rdata.life_left <= 32'sd0);
    assign rd_full_f = $unsigned(ram_rdata.life_left) >= {1'b0, ram_rdata.life_time};

    // Position step: the product is vel * time_step in Q32; an arithmetic
    // shift floors it back to Q16.16, then saturate the sum.
    always_comb begin
        step = 35'(mul_p >>> 16);
        if (r_state == S_TK_Y) begin
            pos_new = sat32(35'(r_rec.pos_x) + step);
        end else begin
            pos_new = sat32(35'(r_rec.pos_y) + step);
        end
    end

    // Blend lane operands: size, then colour bytes from low to high.
    always_comb begin
        case (r_lane)
            LANE_SIZE: begin
                bl_b = r_rec.size_b;
                bl_e = r_rec.size_e;
            end
            LANE_C0: begin
                bl_b = {8'd0, r_rec.col_b[7:0]};
                bl_e = {8'd0, r_rec.col_e[7:0]};
            end
            LANE_C1: begin
                bl_b = {8'd0, r_rec.col_b[15:8]};
                bl_e = {8'd0, r_rec.col_e[15:8]};
            end
            LANE_C2: begin
                bl_b = {8'd0, r_rec.col_b[23:16]};
                bl_e = {8'd0, r_rec.col_e[23:16]};
            end
            default: begin
                bl_b = {8'd0, r_rec.col_b[31:24]};
                bl_e = {8'd0, r_rec.col_e[31:24]};
            end
        endcase
        // end*(1-f) + begin*f folds to end + (begin-end)*f, rounded.
        bl_acc = $signed({4'd0, bl_e, 16'd0}) + 36'(mul_p) + 36'sd32768;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (last_idx) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc && i_op == OP_TICK) begin
                    n_state = S_TK_RD;
                end else if (in_acc && i_op == OP_READ) begin
                    n_state = S_RD_RD;
                end
            end
            S_TK_RD:  n_state = S_TK_CHK;
            S_TK_CHK: begin
                if (ram_rdata.live && !rd_dead) begin
                    n_state = S_TK_Y;
                end else begin
                    n_state = last_idx ? S_IDLE : S_TK_RD;
                end
            end
            S_TK_Y:   n_state = S_TK_WR;
            S_TK_WR:  n_state = last_idx ? S_IDLE : S_TK_RD;
            S_RD_RD:  n_state = S_RD_CHK;
            S_RD_CHK: begin
                if (r_oor || !ram_rdata.live) begin
                    n_state = S_OUT;
                end else if (rd_zero_f || rd_full_f) begin
                    n_state = S_BL_MUL;
                end else begin
                    n_state = S_RD_DIV;
                end
            end
            S_RD_DIV: if (div_rsp.done) n_state = S_BL_MUL;
            S_BL_MUL: n_state = S_BL_ACC;
            S_BL_ACC: n_state = (r_lane == LANE_C3) ? S_OUT : S_BL_MUL;
            S_OUT:    if (!i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory, multiplier and divider controls
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = r_rec;
        ram_re      = 1'b0;
        mul_a       = {r_rec.vel_y[31], r_rec.vel_y};
        mul_b       = {2'b00, r_time_step};
        div_req.start = 1'b0;
        div_req.num = ram_rdata.life_left[30:0];
        div_req.den = ram_rdata.life_time;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_we              = in_acc && i_op == OP_EMIT;
                ram_waddr           = r_next_slot;
                ram_wdata.live      = 1'b1;
                ram_wdata.pos_x     = i_pos_x;
                ram_wdata.pos_y     = i_pos_y;
                ram_wdata.vel_x     = i_vel_x;
                ram_wdata.vel_y     = i_vel_y;
                ram_wdata.rot       = '0;
                ram_wdata.col_b     = i_color_begin;
                ram_wdata.col_e     = i_color_end;
                ram_wdata.life_time = i_life_time;
                ram_wdata.life_left = {1'b0, i_life_time};
                ram_wdata.size_b    = i_size_begin;
                ram_wdata.size_e    = i_size_end;
            end
            S_TK_RD, S_RD_RD: ram_re = 1'b1;
            S_TK_CHK: begin
                ram_we         = rd_dead;
                ram_wdata      = ram_rdata;
                ram_wdata.live = 1'b0;
                mul_a          = {ram_rdata.vel_x[31], ram_rdata.vel_x};
            end
            S_TK_WR: begin
                ram_we              = 1'b1;
                ram_wdata.pos_y     = pos_new;
                ram_wdata.life_left = r_rec.life_left - $signed({16'd0, r_time_step});
                ram_wdata.rot       = r_rec.rot + {8'd0, r_spin_step};
            end
            S_RD_CHK: div_req.start = !r_oor && ram_rdata.live && !rd_zero_f && !rd_full_f;
            S_BL_MUL: begin
                mul_a = 33'($signed({1'b0, bl_b}) - $signed({1'b0, bl_e}));
                mul_b = {1'b0, r_f};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_next_slot <= LAST_SLOT;
            r_time_step <= TIME_STEP_RST;
            r_spin_step <= SPIN_STEP_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIME_STEP: r_time_step <= i_cfg_data[15:0];
                    CFG_SPIN_STEP: r_spin_step <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: r_idx <= r_idx + 1'b1;
                S_IDLE: begin
                    if (in_acc && i_op == OP_EMIT) begin
                        r_next_slot <= (r_next_slot == '0) ? LAST_SLOT : r_next_slot - 1'b1;
                    end
                    if (in_acc && i_op == OP_TICK) begin
                        r_idx <= '0;
                    end else if (in_acc && i_op == OP_READ) begin
                        r_idx <= SLOT_W'(i_slot);
                    end
                end
                S_TK_CHK: if (!(ram_rdata.live && !rd_dead)) r_idx <= r_idx + 1'b1;
                S_TK_WR:  r_idx <= r_idx + 1'b1;
                default: ;
            endcase
        end
    end

    // Payload registers: range flag, record copy, fraction, lane and result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_oor <= 32'(i_slot) >= POOL_SIZE;
            S_TK_CHK: r_rec <= ram_rdata;
            S_TK_Y:   r_rec.pos_x <= pos_new;
            S_RD_CHK: begin
                r_rec        <= ram_rdata;
                r_lane       <= LANE_SIZE;
                r_f          <= rd_zero_f ? 17'd0 : 17'h10000;
                r_out_active <= 1'b0;
                r_out_x      <= '0;
                r_out_y      <= '0;
                r_out_rot    <= '0;
                r_out_size   <= '0;
                r_out_color  <= '0;
                if (!r_oor && ram_rdata.live) begin
                    r_out_active <= 1'b1;
                    r_out_x      <= ram_rdata.pos_x;
                    r_out_y      <= ram_rdata.pos_y;
                    r_out_rot    <= $signed(ram_rdata.rot);
                end
            end
            S_RD_DIV: r_f <= {1'b0, div_rsp.quot};
            S_BL_ACC: begin
                r_lane <= r_lane + 3'd1;
                case (r_lane)
                    LANE_SIZE: r_out_size         <= bl_acc[31:16];
                    LANE_C0:   r_out_color[7:0]   <= bl_acc[23:16];
                    LANE_C1:   r_out_color[15:8]  <= bl_acc[23:16];
                    LANE_C2:   r_out_color[23:16] <= bl_acc[23:16];
                    default:   r_out_color[31:24] <= bl_acc[23:16];
                endcase
            end
            default: ;
        endcase
    end

    ppe_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    ppe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ppe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall        = r_state != S_IDLE;
    assign o_cfg_ready    = r_state == S_IDLE;
    assign o_valid        = r_state == S_OUT;
    assign o_active       = r_out_active;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_rotation = r_out_rot;
    assign o_out_size     = r_out_size;
    assign o_out_color    = r_out_color;

    `PPE_ASSERT_IMP(a_one_in_flight, o_valid, o_stall)
    `PPE_ASSERT_IMP(a_dead_read_zero, o_valid && !o_active, o_out_x == '0 && o_out_color == '0)
    `PPE_ASSERT_NXT(a_ring_hold, !(in_acc && i_op == OP_EMIT), $stable(r_next_slot))
    `PPE_ASSERT_NXT(a_tick_read, r_state == S_TK_RD, r_state == S_TK_CHK)

endmodule
